// ===== sv/sipreq_pkg.sv =====
// Package: codes, field types and word formats for the signalling request tracker.
package sipreq_pkg;

    // Request states
    localparam logic [3:0] ST_INIT         = 4'd0;
    localparam logic [3:0] ST_RUN_INIT     = 4'd1;
    localparam logic [3:0] ST_RUNNING      = 4'd2;
    localparam logic [3:0] ST_ACTIVE       = 4'd3;
    localparam logic [3:0] ST_ACTIVE_SUBS  = 4'd4;
    localparam logic [3:0] ST_STOPPING     = 4'd5;
    localparam logic [3:0] ST_PENDING      = 4'd6;
    localparam logic [3:0] ST_RETRY        = 4'd7;
    localparam logic [3:0] ST_DIALOG_RECRE = 4'd8;
    localparam logic [3:0] ST_FAILED       = 4'd9;
    localparam logic [3:0] ST_COMPLETE     = 4'd10;
    localparam logic [3:0] ST_DELETING     = 4'd11;

    // Completion status
    localparam logic [2:0] CS_OK         = 3'd0;
    localparam logic [2:0] CS_PENDING    = 3'd1;
    localparam logic [2:0] CS_TEMP       = 3'd2;
    localparam logic [2:0] CS_TIMEOUT    = 3'd3;
    localparam logic [2:0] CS_DISCONN    = 3'd4;
    localparam logic [2:0] CS_COMPLETION = 3'd5;
    localparam logic [2:0] CS_OTHER      = 3'd6;
    localparam logic [2:0] CS_ILLEGAL    = 3'd7;

    // Subscription states
    localparam logic [1:0] SUB_NONE       = 2'd0;
    localparam logic [1:0] SUB_PENDING    = 2'd1;
    localparam logic [1:0] SUB_ACTIVE     = 2'd2;
    localparam logic [1:0] SUB_TERMINATED = 2'd3;

    // Pending publish operations
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_MODIFY  = 2'd1;
    localparam logic [1:0] PEND_REFRESH = 2'd2;
    localparam logic [1:0] PEND_BOTH    = 2'd3;

    // Item modes
    localparam logic [1:0] MODE_COMPLETION = 2'd0;
    localparam logic [1:0] MODE_ADD_PEND   = 2'd1;
    localparam logic [1:0] MODE_RETRY      = 2'd2;
    localparam logic [1:0] MODE_FORCE      = 2'd3;

    // Request kinds
    localparam logic [2:0] KIND_REGISTER = 3'd0;
    localparam logic [2:0] KIND_PUBLISH  = 3'd1;
    localparam logic [2:0] KIND_SEND_MSG = 3'd2;
    localparam logic [2:0] KIND_RECV_MSG = 3'd3;
    localparam logic [2:0] KIND_SUBSCR   = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_KIND      = 3'd0;
    localparam logic [2:0] CFG_EXPIRES   = 3'd1;
    localparam logic [2:0] CFG_AUTO      = 3'd2;
    localparam logic [2:0] CFG_REFRESH   = 3'd3;
    localparam logic [2:0] CFG_GIVEN_TAG = 3'd4;

    // Timing constants in seconds, and the precondition response code
    localparam logic [15:0] LONG_REFRESH   = 16'd1200;
    localparam logic [16:0] REFRESH_MARGIN = 17'd600;
    localparam logic [15:0] RETRY_LIMIT    = 16'd300;
    localparam logic [15:0] RETRY_MIN      = 16'd5;
    localparam logic [16:0] NO_AUTO_SLACK  = 17'd5;
    localparam logic [9:0]  CODE_PRECOND   = 10'd412;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  status;
        logic        notify_response;
        logic        modify_request;
        logic [9:0]  sip_code;
        logic        send_failed;
        logic [15:0] retry_seconds;
        logic [1:0]  pending_kind;
        logic [3:0]  forced_state;
    } req_word_t;

    typedef struct packed {
        logic        complete_valid;
        logic [2:0]  complete_code;
        logic [3:0]  request_state;
        logic [1:0]  sub_state;
        logic        refresh_start;
        logic [16:0] refresh_seconds;
        logic        refresh_stop;
        logic        expiry_stop;
        logic        tag_only_notice;
        logic        send_pending;
    } rsp_word_t;

endpackage

// ===== sv/sip_request_completion_fsm.sv =====
// Top level: completion state machine for one signalling request.
// An accepted word passes through the input register and then the result register, which drives rsp.
// Throughput: one word per cycle; req_stall rises only when both registers are full and
// rsp_stall holds the result register, so the next word lands while a result waits.
// Reset (rst_n low, asynchronous): request init, no pending, no subscription, counter and
// retry-after zero, expires_reg one, other configuration zero; both registers empty.
module sip_request_completion_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  sipreq_pkg::req_word_t  req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output sipreq_pkg::rsp_word_t  rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import sipreq_pkg::*;

    // Configuration
    logic [2:0]  kind_reg;
    logic        expires_reg;
    logic        auto_reg;
    logic [15:0] refresh_reg;
    logic        given_tag_reg;

    // Request context
    logic [3:0]  state_reg, state_next;
    logic [1:0]  pend_reg, pend_next;
    logic [1:0]  sub_reg, sub_next;
    logic [1:0]  count_reg, count_next;
    logic [15:0] retry_after_reg, retry_after_next;

    // Input register and result register
    logic        in_valid_reg;
    req_word_t   in_reg;
    logic        out_valid_reg;
    rsp_word_t   out_reg;
    rsp_word_t   out_next;

    logic        advance;
    logic [2:0]  st;
    logic        okish;
    logic [16:0] default_interval;
    logic [15:0] retry_raw;
    logic [15:0] retry_interval;
    logic        retry_fails;

    // The result register takes a word when it is empty or being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !advance;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cfg_ready = 1'b1;

    // Illegal status code seven counts as other error, also in the reported code.
    assign st    = (in_reg.status == CS_ILLEGAL) ? CS_OTHER : in_reg.status;
    assign okish = (st == CS_OK) || (st == CS_PENDING);

    // Refresh interval: half the period, or period minus ten minutes when long;
    // without auto refresh the timer runs slightly past the period.
    always_comb
    begin
        if (!auto_reg)
            default_interval = {1'b0, refresh_reg} + NO_AUTO_SLACK;
        else if (refresh_reg > LONG_REFRESH)
            default_interval = {1'b0, refresh_reg} - REFRESH_MARGIN;
        else
            default_interval = {2'b00, refresh_reg[15:1]};
    end

    // Retry interval: the retry-after value if set, else a quarter period capped at 300.
    always_comb
    begin
        if (retry_after_reg != 16'd0)
            retry_raw = retry_after_reg;
        else if (refresh_reg > LONG_REFRESH)
            retry_raw = RETRY_LIMIT;
        else
            retry_raw = {2'b00, refresh_reg[15:2]};
        retry_interval = (retry_raw > RETRY_MIN) ? retry_raw : RETRY_MIN;
        retry_fails    = retry_interval > RETRY_LIMIT;
    end

    // Next context and result for the word in the input register.
    always_comb
    begin
        state_next       = state_reg;
        pend_next        = pend_reg;
        sub_next         = sub_reg;
        count_next       = count_reg;
        retry_after_next = retry_after_reg;
        out_next         = '0;

        unique case (in_reg.mode)
            MODE_COMPLETION:
            begin
                if (state_reg == ST_DELETING) begin
                    out_next.complete_valid = 1'b1;
                    out_next.complete_code  = st;
                end
                else if (st == CS_DISCONN || (st == CS_TIMEOUT && kind_reg != KIND_PUBLISH))
                begin
                    // Network failure: drop both timers and fail.
                    retry_after_next        = 16'd0;
                    out_next.expiry_stop    = 1'b1;
                    out_next.refresh_stop   = 1'b1;
                    state_next              = ST_FAILED;
                    sub_next                = SUB_TERMINATED;
                    out_next.complete_valid = 1'b1;
                    out_next.complete_code  = st;
                end
                else begin
                    unique case (kind_reg) inside
                        KIND_REGISTER:
                        begin
                            out_next.expiry_stop    = 1'b1;
                            out_next.complete_valid = 1'b1;
                            out_next.complete_code  = st;
                        end
                        KIND_PUBLISH:
                        begin
                            pend_next = PEND_NONE;
                            if (state_reg != ST_PENDING)
                                out_next.refresh_stop = 1'b1;
                            if (state_reg == ST_RUN_INIT) begin
                                out_next.expiry_stop = 1'b1;
                                if (st == CS_OK) begin
                                    state_next               = ST_ACTIVE;
                                    out_next.refresh_start   = 1'b1;
                                    out_next.refresh_seconds = default_interval;
                                end
                                else begin
                                    state_next = ST_FAILED;
                                    sub_next   = SUB_TERMINATED;
                                end
                                out_next.complete_valid = 1'b1;
                                out_next.complete_code  = st;
                            end
                            else if (state_reg == ST_RUNNING) begin
                                if (in_reg.modify_request) begin
                                    state_next = ST_ACTIVE;
                                    if (pend_reg != PEND_NONE) begin
                                        if (st != CS_OK) begin
                                            out_next.expiry_stop    = 1'b1;
                                            out_next.complete_valid = 1'b1;
                                            out_next.complete_code  = CS_COMPLETION;
                                            state_next              = ST_FAILED;
                                            sub_next                = SUB_TERMINATED;
                                        end
                                        else begin
                                            out_next.refresh_start   = 1'b1;
                                            out_next.refresh_seconds = default_interval;
                                            out_next.send_pending    = 1'b1;
                                            if (in_reg.send_failed) begin
                                                out_next.expiry_stop    = 1'b1;
                                                out_next.complete_valid = 1'b1;
                                                out_next.complete_code  = CS_OTHER;
                                            end
                                        end
                                    end
                                    else begin
                                        if ((st == CS_OK || st == CS_TEMP) &&
                                            in_reg.sip_code != CODE_PRECOND) begin
                                            out_next.refresh_start   = 1'b1;
                                            out_next.refresh_seconds = default_interval;
                                            out_next.complete_valid  = 1'b1;
                                            out_next.complete_code   = st;
                                        end
                                        else begin
                                            out_next.complete_valid = 1'b1;
                                            out_next.complete_code  = CS_COMPLETION;
                                            state_next              = ST_FAILED;
                                            sub_next                = SUB_TERMINATED;
                                        end
                                        out_next.expiry_stop = 1'b1;
                                    end
                                end
                                else begin
                                    out_next.expiry_stop = 1'b1;
                                    if (st == CS_OK) begin
                                        out_next.refresh_start   = 1'b1;
                                        out_next.refresh_seconds = default_interval;
                                        state_next               = ST_ACTIVE;
                                        out_next.tag_only_notice = 1'b1;
                                    end
                                    else begin
                                        state_next              = ST_FAILED;
                                        sub_next                = SUB_TERMINATED;
                                        out_next.complete_valid = 1'b1;
                                        out_next.complete_code  = st;
                                    end
                                end
                            end
                            else if (state_reg == ST_STOPPING) begin
                                out_next.expiry_stop    = 1'b1;
                                state_next              = ST_COMPLETE;
                                sub_next                = SUB_TERMINATED;
                                out_next.complete_valid = 1'b1;
                                out_next.complete_code  = given_tag_reg ? st : CS_OK;
                            end
                            else if (state_reg == ST_PENDING &&
                                     (pend_reg == PEND_MODIFY || pend_reg == PEND_BOTH) &&
                                     st != CS_COMPLETION) begin
                                out_next.expiry_stop    = 1'b1;
                                out_next.complete_valid = 1'b1;
                                out_next.complete_code  = st;
                                state_next              = ST_ACTIVE;
                                // Modify failed with a refresh queued: keep the refresh.
                                if (pend_reg == PEND_BOTH && st != CS_OK) begin
                                    state_next = ST_PENDING;
                                    pend_next  = PEND_REFRESH;
                                end
                            end
                            else begin
                                out_next.expiry_stop    = 1'b1;
                                state_next              = ST_FAILED;
                                sub_next                = SUB_TERMINATED;
                                out_next.complete_valid = 1'b1;
                                out_next.complete_code  = st;
                            end
                        end
                        KIND_SEND_MSG, KIND_RECV_MSG:
                        begin
                            out_next.complete_valid = 1'b1;
                            out_next.complete_code  = st;
                        end
                        KIND_SUBSCR:
                        begin
                            if (in_reg.notify_response) begin
                                if (okish) begin
                                    sub_next = (st == CS_PENDING) ? SUB_PENDING : SUB_ACTIVE;
                                    if (state_reg == ST_STOPPING && st != CS_OK) begin
                                        count_next = count_reg + 2'd1;
                                        if (count_next == 2'd2) begin
                                            state_next           = ST_COMPLETE;
                                            sub_next             = SUB_TERMINATED;
                                            out_next.expiry_stop = 1'b1;
                                        end
                                    end
                                    out_next.complete_valid = 1'b1;
                                    out_next.complete_code  = st;
                                end
                                else if (state_reg == ST_ACTIVE_SUBS) begin
                                    if (auto_reg && st == CS_TEMP) begin
                                        out_next.refresh_stop = 1'b1;
                                        if (retry_fails) begin
                                            state_next              = ST_FAILED;
                                            sub_next                = SUB_TERMINATED;
                                            out_next.complete_valid = 1'b1;
                                            out_next.complete_code  = CS_COMPLETION;
                                        end
                                        else begin
                                            state_next               = ST_RETRY;
                                            out_next.refresh_start   = 1'b1;
                                            out_next.refresh_seconds = {1'b0, retry_interval};
                                        end
                                    end
                                    else begin
                                        state_next = (st == CS_TIMEOUT || st == CS_COMPLETION)
                                                     ? ST_COMPLETE : ST_FAILED;
                                        sub_next                = SUB_TERMINATED;
                                        out_next.complete_valid = 1'b1;
                                        out_next.complete_code  = st;
                                    end
                                end
                                else begin
                                    out_next.complete_valid = 1'b1;
                                    out_next.complete_code  = st;
                                end
                            end
                            else begin
                                if (state_reg != ST_STOPPING)
                                    out_next.expiry_stop = 1'b1;
                                if (state_reg != ST_RUN_INIT)
                                    out_next.refresh_stop = 1'b1;
                                if (state_reg == ST_RUN_INIT) begin
                                    if (okish) begin
                                        if (expires_reg) begin
                                            if (st == CS_PENDING)
                                                sub_next = SUB_PENDING;
                                            state_next = ST_ACTIVE_SUBS;
                                        end
                                        else begin
                                            state_next = ST_COMPLETE;
                                            sub_next   = SUB_TERMINATED;
                                        end
                                    end
                                    else begin
                                        state_next = ST_FAILED;
                                        sub_next   = SUB_TERMINATED;
                                    end
                                    out_next.complete_valid = 1'b1;
                                    out_next.complete_code  = st;
                                end
                                else if (state_reg == ST_ACTIVE_SUBS) begin
                                    if (retry_fails) begin
                                        state_next              = ST_FAILED;
                                        sub_next                = SUB_TERMINATED;
                                        out_next.complete_valid = 1'b1;
                                        out_next.complete_code  = CS_COMPLETION;
                                    end
                                    else begin
                                        state_next               = ST_RETRY;
                                        out_next.refresh_start   = 1'b1;
                                        out_next.refresh_seconds = {1'b0, retry_interval};
                                    end
                                end
                                else if (state_reg == ST_STOPPING) begin
                                    // Unsubscribe finishes on an error or the second answer.
                                    count_next = count_reg + 2'd1;
                                    if (!okish || count_next == 2'd2) begin
                                        state_next           = ST_COMPLETE;
                                        sub_next             = SUB_TERMINATED;
                                        out_next.expiry_stop = 1'b1;
                                    end
                                    out_next.complete_valid = 1'b1;
                                    out_next.complete_code  = st;
                                end
                                else if (state_reg == ST_DIALOG_RECRE && st == CS_OK) begin
                                    state_next = ST_ACTIVE_SUBS;
                                end
                                else begin
                                    state_next              = ST_FAILED;
                                    sub_next                = SUB_TERMINATED;
                                    out_next.complete_valid = 1'b1;
                                    out_next.complete_code  = st;
                                end
                            end
                        end
                        default:
                        begin
                            // Other kinds: nothing beyond the common checks.
                        end
                    endcase
                end
            end
            MODE_ADD_PEND:
            begin
                if ((in_reg.pending_kind == PEND_MODIFY && pend_reg == PEND_REFRESH) ||
                    (in_reg.pending_kind == PEND_REFRESH && pend_reg == PEND_MODIFY))
                    pend_next = PEND_BOTH;
                else if (in_reg.pending_kind == PEND_MODIFY && pend_reg == PEND_NONE)
                    pend_next = PEND_MODIFY;
                else if (in_reg.pending_kind == PEND_REFRESH && pend_reg == PEND_NONE)
                    pend_next = PEND_REFRESH;
            end
            MODE_RETRY:
            begin
                retry_after_next = in_reg.retry_seconds;
            end
            MODE_FORCE:
            begin
                if (in_reg.forced_state <= ST_DELETING) begin
                    state_next = in_reg.forced_state;
                    if (in_reg.forced_state == ST_FAILED || in_reg.forced_state == ST_COMPLETE ||
                        in_reg.forced_state == ST_DELETING)
                        sub_next = SUB_TERMINATED;
                end
            end
            default:
            begin
            end
        endcase

        out_next.request_state = state_next;
        out_next.sub_state     = sub_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kind_reg      <= KIND_REGISTER;
            expires_reg   <= 1'b1;
            auto_reg      <= 1'b0;
            refresh_reg   <= 16'd0;
            given_tag_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_KIND:      kind_reg      <= cfg_data[2:0];
                CFG_EXPIRES:   expires_reg   <= cfg_data[0];
                CFG_AUTO:      auto_reg      <= cfg_data[0];
                CFG_REFRESH:   refresh_reg   <= cfg_data;
                CFG_GIVEN_TAG: given_tag_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Context and handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_INIT;
            pend_reg        <= PEND_NONE;
            sub_reg         <= SUB_NONE;
            count_reg       <= 2'd0;
            retry_after_reg <= 16'd0;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            if (advance) begin
                state_reg       <= state_next;
                pend_reg        <= pend_next;
                sub_reg         <= sub_next;
                count_reg       <= count_next;
                retry_after_reg <= retry_after_next;
            end
            if (req_valid && !req_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_reg <= req;
        if (advance)
            out_reg <= out_next;
    end

endmodule
